>>> rtl/i2cbm_pkg.sv
// Shared types and constants of the bit-level I2C master.
package i2cbm_pkg;

	// Command codes, equal to the mode field codes
	typedef enum logic [2:0] {
		CMD_NONE  = 3'd0,
		CMD_START = 3'd1,
		CMD_STOP  = 3'd2,
		CMD_WRITE = 3'd3,
		CMD_READ  = 3'd4
	} cmd_t;

	// Bus sequencer steps; each step is one held bus phase
	typedef enum logic [2:0] {
		STEP_IDLE = 3'd0,
		STEP_P1   = 3'd1,
		STEP_P2   = 3'd2,
		STEP_P3   = 3'd3,
		STEP_P4   = 3'd4,
		STEP_P5   = 3'd5,
		STEP_P6   = 3'd6
	} step_t;

	// Input transaction: one tick of the bus engine
	typedef struct packed {
		logic [2:0] mode;
		logic [7:0] wr_byte;
		logic       send_nack;
		logic       sda_in;
	} cmd_item_t;

	// Result transaction: pin levels and status after the tick
	typedef struct packed {
		logic       scl;
		logic       sda_out;
		logic       sda_oe;
		logic       busy_res;
		logic       done_res;
		logic       ack_ok;
		logic [7:0] rx_byte;
	} res_item_t;

	// Classified tick as held in the queue
	typedef struct packed {
		cmd_t       cmd;
		logic [7:0] wr_byte;
		logic       send_nack;
		logic       sda_in;
	} tick_t;

	// Register map
	localparam int unsigned PADDR_W          = 3;
	localparam logic        REG_PHASE_LENGTH = 1'b0;
	localparam logic [7:0]  PHASE_LENGTH_RST = 8'd32;
	localparam logic [2:0]  LAST_BIT         = 3'd7;

endpackage

>>> rtl/i2cbm_front.sv
// Front end: accept ticks and classify the mode field into a command.
module i2cbm_front (
	input  i2cbm_pkg::cmd_item_t cmd,
	input  logic                 cmd_valid,
	output logic                 cmd_stall,
	output i2cbm_pkg::tick_t     push_tick,
	output logic                 push_en,
	input  logic                 q_full
);
	import i2cbm_pkg::*;

	// Decode mode; unknown codes become no command
	always_comb begin
		unique case (cmd.mode)
			CMD_START: push_tick.cmd = CMD_START;
			CMD_STOP:  push_tick.cmd = CMD_STOP;
			CMD_WRITE: push_tick.cmd = CMD_WRITE;
			CMD_READ:  push_tick.cmd = CMD_READ;
			default:   push_tick.cmd = CMD_NONE;
		endcase
		push_tick.wr_byte   = cmd.wr_byte;
		push_tick.send_nack = cmd.send_nack;
		push_tick.sda_in    = cmd.sda_in;
	end

	// Stall while the queue has no room
	assign cmd_stall = q_full;
	assign push_en   = cmd_valid & ~q_full;

endmodule

>>> rtl/i2cbm_queue.sv
// Two-entry queue between the front end and the bus engine.
module i2cbm_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  i2cbm_pkg::tick_t push_tick,
	input  logic             push_en,
	output logic             full,
	output i2cbm_pkg::tick_t pop_tick,
	output logic             pop_valid,
	input  logic             pop_en
);
	import i2cbm_pkg::*;

	tick_t      mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full      = (count_q == 2'd2);
	assign pop_valid = (count_q != 2'd0);
	assign pop_tick  = mem_q[rd_ptr_q];

	// Store pushed entries
	always_ff @(posedge clk) begin
		if (push_en) begin
			mem_q[wr_ptr_q] <= push_tick;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push_en) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop_en) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push_en, pop_en})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> rtl/i2cbm_engine.sv
// Back end: bus phase sequencer and result output register.
module i2cbm_engine (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [7:0]           phase_length,
	input  i2cbm_pkg::tick_t     pop_tick,
	input  logic                 pop_valid,
	output logic                 pop_en,
	output i2cbm_pkg::res_item_t res,
	output logic                 res_valid,
	input  logic                 res_stall
);
	import i2cbm_pkg::*;

	step_t      step_q, n_step;
	cmd_t       cmd_q, n_cmd;
	logic [3:0] bit_q, n_bit;
	logic [7:0] timer_q, n_timer;
	logic [7:0] shift_q, n_shift;
	logic [7:0] tx_q, n_tx;
	logic       scl_q, n_scl;
	logic       sda_q, n_sda;
	logic       oe_q, n_oe;
	logic       ack_q, n_ack;
	logic       nack_q, n_nack;

	logic       enter_en;
	step_t      enter_step;
	logic       phase_end;
	logic       finish;
	logic       load_cmd;
	step_t      last_step;
	logic       is_rw;
	logic [7:0] eff_len;

	res_item_t  res_q;
	logic       res_valid_q;

	// Take a tick when the output register is free or draining
	assign pop_en    = pop_valid & (~res_valid_q | ~res_stall);
	assign eff_len   = (phase_length == 8'd0) ? 8'd1 : phase_length;
	assign last_step = (cmd_q == CMD_START || cmd_q == CMD_STOP) ? STEP_P3 : STEP_P6;
	assign is_rw     = (cmd_q == CMD_WRITE || cmd_q == CMD_READ);

	// Next step, timer and bit counter
	always_comb begin
		n_step     = step_q;
		n_cmd      = cmd_q;
		n_bit      = bit_q;
		n_timer    = timer_q;
		enter_en   = 1'b0;
		enter_step = STEP_P1;
		phase_end  = 1'b0;
		finish     = 1'b0;
		load_cmd   = 1'b0;
		if (step_q == STEP_IDLE) begin
			if (pop_tick.cmd != CMD_NONE) begin
				load_cmd   = 1'b1;
				n_cmd      = pop_tick.cmd;
				n_bit      = 4'd0;
				enter_en   = 1'b1;
				enter_step = STEP_P1;
			end
		end else if (timer_q > 8'd1) begin
			n_timer = timer_q - 8'd1;
		end else begin
			phase_end = 1'b1;
			if (is_rw && step_q == STEP_P3 && bit_q < {1'b0, LAST_BIT}) begin
				n_bit      = bit_q + 4'd1;
				enter_en   = 1'b1;
				enter_step = (cmd_q == CMD_WRITE) ? STEP_P1 : STEP_P2;
			end else if (step_q >= last_step) begin
				finish  = 1'b1;
				n_step  = STEP_IDLE;
				n_cmd   = CMD_NONE;
				n_timer = 8'd0;
			end else begin
				enter_en   = 1'b1;
				enter_step = step_t'(step_q + 3'd1);
			end
		end
		if (enter_en) begin
			n_step  = enter_step;
			n_timer = eff_len;
		end
	end

	// Pin levels, sampling and data latches
	always_comb begin
		n_shift = shift_q;
		n_tx    = tx_q;
		n_scl   = scl_q;
		n_sda   = sda_q;
		n_oe    = oe_q;
		n_ack   = ack_q;
		n_nack  = nack_q;
		// latch command operands
		if (load_cmd && pop_tick.cmd == CMD_WRITE) begin
			n_tx = pop_tick.wr_byte;
		end
		if (load_cmd && pop_tick.cmd == CMD_READ) begin
			n_nack  = pop_tick.send_nack;
			n_shift = 8'd0;
		end
		// sample SDA at the end of a clock-high phase
		if (phase_end && cmd_q == CMD_WRITE && step_q == STEP_P5) begin
			n_ack = ~pop_tick.sda_in;
		end
		if (phase_end && cmd_q == CMD_READ && step_q == STEP_P2) begin
			n_shift = {shift_q[6:0], pop_tick.sda_in};
		end
		// drive SDA high once a read completes
		if (finish && cmd_q == CMD_READ) begin
			n_sda = 1'b1;
			n_oe  = 1'b1;
		end
		// set the levels of the phase being entered
		if (enter_en) begin
			unique case (n_cmd)
				CMD_START: begin
					if (enter_step == STEP_P1) begin
						n_sda = 1'b1;
						n_oe  = 1'b1;
						n_scl = 1'b1;
					end else if (enter_step == STEP_P2) begin
						n_sda = 1'b0;
					end else begin
						n_scl = 1'b0;
					end
				end
				CMD_STOP: begin
					if (enter_step == STEP_P1) begin
						n_scl = 1'b0;
						n_sda = 1'b0;
						n_oe  = 1'b1;
					end else if (enter_step == STEP_P2) begin
						n_scl = 1'b1;
					end else begin
						n_sda = 1'b1;
					end
				end
				CMD_WRITE: begin
					if (enter_step == STEP_P1) begin
						n_sda = n_tx[LAST_BIT - n_bit[2:0]];
						n_oe  = 1'b1;
					end else if (enter_step == STEP_P4) begin
						n_oe = 1'b0;
					end else if (enter_step == STEP_P2 || enter_step == STEP_P5) begin
						n_scl = 1'b1;
					end else begin
						n_scl = 1'b0;
					end
				end
				default: begin
					if (enter_step == STEP_P1) begin
						n_oe = 1'b0;
					end else if (enter_step == STEP_P4) begin
						n_sda = n_nack;
						n_oe  = 1'b1;
					end else if (enter_step == STEP_P2 || enter_step == STEP_P5) begin
						n_scl = 1'b1;
					end else begin
						n_scl = 1'b0;
					end
				end
			endcase
		end
	end

	// Advance engine state once per tick taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= STEP_IDLE;
			cmd_q   <= CMD_NONE;
			bit_q   <= 4'd0;
			timer_q <= 8'd0;
			shift_q <= 8'd0;
			tx_q    <= 8'd0;
			scl_q   <= 1'b1;
			sda_q   <= 1'b1;
			oe_q    <= 1'b0;
			ack_q   <= 1'b0;
			nack_q  <= 1'b0;
		end else if (pop_en) begin
			step_q  <= n_step;
			cmd_q   <= n_cmd;
			bit_q   <= n_bit;
			timer_q <= n_timer;
			shift_q <= n_shift;
			tx_q    <= n_tx;
			scl_q   <= n_scl;
			sda_q   <= n_sda;
			oe_q    <= n_oe;
			ack_q   <= n_ack;
			nack_q  <= n_nack;
		end
	end

	// Hold result valid until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (pop_en) begin
			res_valid_q <= 1'b1;
		end else if (~res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	// Load the result payload
	always_ff @(posedge clk) begin
		if (pop_en) begin
			res_q.scl      <= n_scl;
			res_q.sda_out  <= n_oe ? n_sda : 1'b1;
			res_q.sda_oe   <= n_oe;
			res_q.busy_res <= (n_step != STEP_IDLE);
			res_q.done_res <= finish;
			res_q.ack_ok   <= n_ack;
			res_q.rx_byte  <= n_shift;
		end
	end

	assign res       = res_q;
	assign res_valid = res_valid_q;

endmodule

>>> rtl/i2c_bit_level_master.sv
// Top level of the tick-driven bit-level I2C master with its register port.
//
//  channel | direction | payload type | handshake
//  cmd     | in        | cmd_item_t   | cmd_valid / cmd_stall
//  res     | out       | res_item_t   | res_valid / res_stall
//  apb     | in/out    | 32-bit data  | psel / penable / pready
//
// One tick is taken per clock while no side stalls; each gives one result.
// The rate is set by the sequencer register update, done once per tick.
// A two-entry queue and an output register let either side stall alone.
// Reset puts the bus idle: SCL high, SDA released, phase_length at 32.
module i2c_bit_level_master (
	input  logic                          clk,
	input  logic                          arst_n,
	input  i2cbm_pkg::cmd_item_t          cmd,
	input  logic                          cmd_valid,
	output logic                          cmd_stall,
	output i2cbm_pkg::res_item_t          res,
	output logic                          res_valid,
	input  logic                          res_stall,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [i2cbm_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);
	import i2cbm_pkg::*;

	logic [7:0] phase_length_q;
	tick_t      push_tick;
	logic       push_en;
	logic       q_full;
	tick_t      pop_tick;
	logic       pop_valid;
	logic       pop_en;
	logic       reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = paddr[PADDR_W-1];

	// Write the phase length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_length_q <= PHASE_LENGTH_RST;
		end else if (psel && penable && pwrite && reg_sel == REG_PHASE_LENGTH) begin
			phase_length_q <= pwdata[7:0];
		end
	end

	// Read back
	always_comb begin
		unique case (reg_sel)
			REG_PHASE_LENGTH: prdata = {24'd0, phase_length_q};
			default:          prdata = 32'd0;
		endcase
	end

	i2cbm_front u_front (
		.cmd       (cmd),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.push_tick (push_tick),
		.push_en   (push_en),
		.q_full    (q_full)
	);

	i2cbm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_tick (push_tick),
		.push_en   (push_en),
		.full      (q_full),
		.pop_tick  (pop_tick),
		.pop_valid (pop_valid),
		.pop_en    (pop_en)
	);

	i2cbm_engine u_engine (
		.clk          (clk),
		.arst_n       (arst_n),
		.phase_length (phase_length_q),
		.pop_tick     (pop_tick),
		.pop_valid    (pop_valid),
		.pop_en       (pop_en),
		.res          (res),
		.res_valid    (res_valid),
		.res_stall    (res_stall)
	);

endmodule
